>>> rtl/xml_text_escaper_macros.svh
// ----------------------------------------------------------------------------
// xml_text_escaper_macros.svh
// Assertion macros used by the escaper top level.
// ----------------------------------------------------------------------------
`ifndef XML_TEXT_ESCAPER_MACROS_SVH
`define XML_TEXT_ESCAPER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off during reset
`define XTE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define XTE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define XTE_ASSERT_IMP(label, ante, cons, msg)
`define XTE_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

>>> rtl/xte_pkg.sv
// ----------------------------------------------------------------------------
// xte_pkg
// Types and character constants of the XML text escaper.
// ----------------------------------------------------------------------------
`default_nettype none

package xte_pkg;

    localparam int SEQ_MAX = 6;
    localparam int CNT_W   = 3;

    localparam logic [7:0] CH_AMP   = "&";
    localparam logic [7:0] CH_LT    = "<";
    localparam logic [7:0] CH_GT    = ">";
    localparam logic [7:0] CH_QUOT  = "\"";
    localparam logic [7:0] CH_QMARK = "?";
    localparam logic [7:0] CH_SEMI  = ";";
    localparam logic [7:0] CH_A     = "a";
    localparam logic [7:0] CH_M     = "m";
    localparam logic [7:0] CH_P     = "p";
    localparam logic [7:0] CH_L     = "l";
    localparam logic [7:0] CH_G     = "g";
    localparam logic [7:0] CH_T     = "t";
    localparam logic [7:0] CH_Q     = "q";
    localparam logic [7:0] CH_U     = "u";
    localparam logic [7:0] CH_O     = "o";
    localparam logic [7:0] CTRL_END = 8'd32;

    // entry 0 is sent first
    typedef logic [SEQ_MAX-1:0][7:0] seq_bytes_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        seq_bytes_t       bytes;
    } esc_seq_t;

    typedef struct packed {
        logic free;
        logic empty;
    } emit_status_t;

endpackage

`default_nettype wire

>>> rtl/xte_if.sv
// ----------------------------------------------------------------------------
// xte_if
// Handshake channels of the escaper: text bytes in, escaped bytes out.
// ----------------------------------------------------------------------------
`default_nettype none

interface xte_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       first_of_string;

    modport source (output valid, output char_byte, output first_of_string, input ready);
    modport sink   (input valid, input char_byte, input first_of_string, output ready);
endinterface

interface xte_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

`default_nettype wire

>>> rtl/xml_text_escaper.sv
// An accepted item is held in the input register and then loaded into the emitter, which
// presents its first output byte. Throughput: one item per cycle for plain bytes while
// dout.ready is high; an entity holds the input until its last byte is on the one-byte
// output port. Truncated bytes are discarded from the input register with no output.
// Reset (rst_n, async, active low) empties both stages and clears the output length.
// ----------------------------------------------------------------------------
// xml_text_escaper
// XML text escaper: entity substitution, control-byte masking and per-string truncation.
// ----------------------------------------------------------------------------
`default_nettype none

`include "xml_text_escaper_macros.svh"

module xml_text_escaper
    import xte_pkg::*;
#(
    parameter int BUFFER_BYTES = 1024
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    xte_in_if.sink    din,
    xte_out_if.source dout
);

    logic         in_vld_reg;
    logic         in_vld_next;
    logic [7:0]   in_char_reg;
    logic         in_first_reg;
    logic         advance;
    logic         accept;
    logic         drop;
    logic         load;
    esc_seq_t     seq;
    emit_status_t status;

    // input register moves on once the emitter can take a new sequence
    assign advance   = in_vld_reg && status.free;
    assign din.ready = !in_vld_reg || advance;
    assign accept    = din.valid && din.ready;
    assign load      = advance && !drop;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (accept)
            in_vld_next = 1'b1;
        else if (advance)
            in_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= in_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_char_reg  <= din.char_byte;
            in_first_reg <= din.first_of_string;
        end
    end

    xte_lookup u_lookup (
        .char_byte (in_char_reg),
        .seq       (seq)
    );

    xte_length #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_length (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .first   (in_first_reg),
        .count   (seq.count),
        .drop    (drop)
    );

    xte_emitter u_emitter (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load),
        .seq    (seq),
        .status (status),
        .dout   (dout)
    );

    `XTE_ASSERT_NXT(a_hold_input, in_vld_reg && !advance, in_vld_reg && $stable(in_char_reg), "input item lost while emitter busy")
    `XTE_ASSERT_NXT(a_drop_no_output, advance && drop, !dout.valid, "truncated item produced output")
    `XTE_ASSERT_NXT(a_escape_stalls, load && (seq.count > CNT_W'(1)), !advance, "next item taken during an entity")
    `XTE_ASSERT_IMP(a_free_when_empty, status.empty, status.free && !dout.valid, "empty emitter not free")

endmodule

`default_nettype wire

>>> rtl/xte_lookup.sv
// ----------------------------------------------------------------------------
// xte_lookup
// Maps one text byte to its escaped byte sequence and length.
// ----------------------------------------------------------------------------
`default_nettype none

module xte_lookup
    import xte_pkg::*;
(
    input  wire logic [7:0] char_byte,
    output esc_seq_t        seq
);

    always_comb
    begin
        seq.bytes = '0;
        seq.count = '0;
        priority if (char_byte == CH_AMP)
        begin
            seq.bytes[0] = CH_AMP;
            seq.bytes[1] = CH_A;
            seq.bytes[2] = CH_M;
            seq.bytes[3] = CH_P;
            seq.bytes[4] = CH_SEMI;
            seq.count    = CNT_W'(5);
        end
        else if (char_byte == CH_LT)
        begin
            seq.bytes[0] = CH_AMP;
            seq.bytes[1] = CH_L;
            seq.bytes[2] = CH_T;
            seq.bytes[3] = CH_SEMI;
            seq.count    = CNT_W'(4);
        end
        else if (char_byte == CH_GT)
        begin
            seq.bytes[0] = CH_AMP;
            seq.bytes[1] = CH_G;
            seq.bytes[2] = CH_T;
            seq.bytes[3] = CH_SEMI;
            seq.count    = CNT_W'(4);
        end
        else if (char_byte == CH_QUOT)
        begin
            seq.bytes[0] = CH_AMP;
            seq.bytes[1] = CH_Q;
            seq.bytes[2] = CH_U;
            seq.bytes[3] = CH_O;
            seq.bytes[4] = CH_T;
            seq.bytes[5] = CH_SEMI;
            seq.count    = CNT_W'(6);
        end
        else if (char_byte < CTRL_END)
        begin
            // control bytes, zero included
            seq.bytes[0] = CH_QMARK;
            seq.count    = CNT_W'(1);
        end
        else
        begin
            seq.bytes[0] = char_byte;
            seq.count    = CNT_W'(1);
        end
    end

endmodule

`default_nettype wire

>>> rtl/xte_length.sv
// ----------------------------------------------------------------------------
// xte_length
// Running output length per string and the truncation decision.
// ----------------------------------------------------------------------------
`default_nettype none

module xte_length
    import xte_pkg::*;
#(
    parameter int BUFFER_BYTES = 1024
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             advance,
    input  wire logic             first,
    input  wire logic [CNT_W-1:0] count,
    output logic                  drop
);

    localparam int LW = $clog2(BUFFER_BYTES);
    localparam logic [LW-1:0] LIMIT = LW'(BUFFER_BYTES - 8);

    logic [LW-1:0] len_reg;
    logic [LW-1:0] len_next;
    logic [LW-1:0] base;

    always_comb
    begin
        base = first ? '0 : len_reg;
        drop = (base > LIMIT);
        len_next = len_reg;
        if (advance)
        begin
            // length holds once past the limit, so the rest of the string drops
            len_next = drop ? base : base + LW'(count);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            len_reg <= '0;
        else
            len_reg <= len_next;
    end

endmodule

`default_nettype wire

>>> rtl/xte_emitter.sv
// ----------------------------------------------------------------------------
// xte_emitter
// Holds one escaped sequence and shifts it out one byte per output handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module xte_emitter
    import xte_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     load,
    input  wire esc_seq_t seq,
    output emit_status_t  status,
    xte_out_if.source     dout
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    seq_bytes_t       bytes_reg;
    seq_bytes_t       bytes_next;
    logic             pop;

    assign pop = dout.valid && dout.ready;

    assign status.empty = (count_reg == '0);
    assign status.free  = status.empty || ((count_reg == CNT_W'(1)) && dout.ready);

    always_comb
    begin
        count_next = count_reg;
        bytes_next = bytes_reg;
        if (load)
        begin
            count_next = seq.count;
            bytes_next = seq.bytes;
        end
        else if (pop)
        begin
            count_next = count_reg - CNT_W'(1);
            bytes_next = {8'h00, bytes_reg[SEQ_MAX-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
    end

    assign dout.valid       = !status.empty;
    assign dout.out_byte    = bytes_reg[0];
    assign dout.last_of_run = (count_reg == CNT_W'(1));

endmodule

`default_nettype wire
